/* hw/rtl/rbd_pkg.sv */
package rbd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int VAL_W      = 32;
    localparam int OCC_W      = 5;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // one access to the entry store per item
    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic [IDX_W-1:0]      addr;
        logic [DATA_WIDTH-1:0] wdata;
    } t_mem_req;

    // result bookkeeping that travels alongside the store read
    typedef struct packed {
        logic             valid;
        t_status          status;
        logic             pop_sel;
        logic [CNT_W-1:0] count;
    } t_rsp;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
    endfunction

endpackage

/* hw/rtl/rbd_mem.sv */
module rbd_mem
    import rbd_pkg::*;
(
    input  logic                  i_clk,
    input  t_mem_req              i_req,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/rbd_ctrl.sv */
module rbd_ctrl
    import rbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [1:0]            i_op,
    input  logic [DATA_WIDTH-1:0] i_data,
    output t_mem_req              o_mem_req,
    output t_rsp                  o_rsp
);

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_valid, n_valid;
    t_status          r_status, n_status;
    logic             r_pop_sel, n_pop_sel;
    logic             w_full;
    logic             w_empty;
    t_mem_req         w_req;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_valid   = i_accept;
        n_status  = r_status;
        n_pop_sel = r_pop_sel;
        w_req     = '{wr_en: 1'b0, rd_en: 1'b0, addr: r_tail, wdata: i_data};
        if (i_accept) begin
            n_status  = ST_DONE;
            n_pop_sel = 1'b0;
            case (t_op'(i_op))
                OP_PUSH_BACK: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_req.wr_en = 1'b1;
                        w_req.addr  = r_tail;
                        n_tail      = idx_next(r_tail);
                        n_count     = r_count + CNT_W'(1);
                    end
                end
                OP_PUSH_FRONT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_req.wr_en = 1'b1;
                        w_req.addr  = idx_prev(r_head);
                        n_head      = idx_prev(r_head);
                        n_count     = r_count + CNT_W'(1);
                    end
                end
                OP_POP_BACK: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_req.rd_en = 1'b1;
                        w_req.addr  = idx_prev(r_tail);
                        n_tail      = idx_prev(r_tail);
                        n_count     = r_count - CNT_W'(1);
                        n_pop_sel   = 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_req.rd_en = 1'b1;
                        w_req.addr  = r_head;
                        n_head      = idx_next(r_head);
                        n_count     = r_count - CNT_W'(1);
                        n_pop_sel   = 1'b1;
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_valid   <= 1'b0;
            r_status  <= ST_DONE;
            r_pop_sel <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_status  <= n_status;
            r_pop_sel <= n_pop_sel;
        end
    end

    assign o_mem_req = w_req;
    assign o_rsp     = '{valid: r_valid, status: r_status, pop_sel: r_pop_sel,
                         count: r_count};

endmodule

/* hw/rtl/ring_buffer_deque_core.sv */
// The result strobe o_valid rises the cycle after start is taken.
// Throughput: one item per cycle; busy stays low, since an item touches at most one store entry
//   at acceptance and a pop's registered read data lands on the result cycle.
// Reset: synchronous, active low; pointers and count clear, the deque is empty.
//   Store contents are not cleared; the count keeps unwritten entries from being read.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ring_buffer_deque_core
    import rbd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_op,
    input  logic signed [VAL_W-1:0] i_push_value,
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_pop_value,
    output logic [1:0]              o_status,
    output logic [OCC_W-1:0]        o_occupancy
);

    logic                         w_accept;
    t_mem_req                     w_mem_req;
    t_rsp                         w_rsp;
    logic [DATA_WIDTH-1:0]        w_rdata;
    logic signed [DATA_WIDTH-1:0] w_rdata_s;

    // every op is at most a single store access, so there is nothing to wait on
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // pointer/count bookkeeping; issues the one store access per item
    rbd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_op      (i_op),
        .i_data    (i_push_value[DATA_WIDTH-1:0]),
        .o_mem_req (w_mem_req),
        .o_rsp     (w_rsp)
    );

    // entry store: write on push, registered read on pop.
    // A pop right after a push to the same slot reads after the write edge, so
    // no forwarding path is needed.
    rbd_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    // popped word is sign-extended from the stored width; zero on anything else
    assign w_rdata_s   = signed'(w_rdata);
    assign o_valid     = w_rsp.valid;
    assign o_pop_value = w_rsp.pop_sel ? VAL_W'(w_rdata_s) : '0;
    assign o_status    = w_rsp.status;
    assign o_occupancy = OCC_W'(w_rsp.count);

    // each accepted item yields a result on the following cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("accepted item produced no result");

    // a pop on an empty deque returns zero and reports zero occupancy
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_pop_value == '0 && o_occupancy == '0))
        else $error("empty pop returned data or nonzero occupancy");

    // a dropped push only happens at full occupancy, and leaves it there
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (w_rsp.count == CNT_W'(DEPTH)))
        else $error("full status without a full deque");

endmodule

/* test/ring_buffer_deque_checker.sv */
`timescale 1ns / 100ps
module ring_buffer_deque_checker
    import rbd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [1:0]              i_op,
    input  logic signed [VAL_W-1:0] i_push_value,
    input  logic                    i_valid,
    input  logic signed [VAL_W-1:0] i_pop_value,
    input  logic [1:0]              i_status,
    input  logic [OCC_W-1:0]        i_occupancy,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int REPORT_CAP = 40;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [1:0]              status;
        logic [OCC_W-1:0]        occ;
    } t_deque_result;

    // shadow deque
    logic [DATA_WIDTH-1:0] words [DEPTH];
    logic [IDX_W-1:0]      front_idx;
    logic [IDX_W-1:0]      back_idx;
    logic [CNT_W-1:0]      held;

    t_deque_result results_due [$];
    t_deque_result predicted;
    t_deque_result observed;
    t_deque_result oldest;
    int            fails = 0;

    task automatic deque_apply(input t_op op, input logic [VAL_W-1:0] value,
                               output t_deque_result res);
        res.value  = '0;
        res.status = ST_DONE;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (held >= CNT_W'(DEPTH)) begin
                    res.status = ST_FULL;
                end else if (op == OP_PUSH_BACK) begin
                    words[back_idx] = value[DATA_WIDTH-1:0];
                    back_idx = IDX_W'((int'(back_idx) + 1) % DEPTH);
                    held = held + 1'b1;
                end else begin
                    front_idx = IDX_W'((int'(front_idx) + DEPTH - 1) % DEPTH);
                    words[front_idx] = value[DATA_WIDTH-1:0];
                    held = held + 1'b1;
                end
            end
            default: begin
                if (held == '0) begin
                    res.status = ST_EMPTY;
                end else if (op == OP_POP_BACK) begin
                    back_idx = IDX_W'((int'(back_idx) + DEPTH - 1) % DEPTH);
                    res.value = VAL_W'($signed(words[back_idx]));
                    held = held - 1'b1;
                end else begin
                    res.value = VAL_W'($signed(words[front_idx]));
                    front_idx = IDX_W'((int'(front_idx) + 1) % DEPTH);
                    held = held - 1'b1;
                end
            end
        endcase
        res.occ = OCC_W'(held);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_idx = '0;
            back_idx  = '0;
            held      = '0;
            results_due.delete();
        end else begin
            // accepted item first, so a same-edge result still finds it
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                deque_apply(t_op'(i_op), i_push_value, predicted);
                results_due.push_back(predicted);
            end
            if (i_valid !== 1'b0) begin
                observed = {i_pop_value, i_status, i_occupancy};
                if (results_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_CAP)
                        $display("%0t: unexpected result value=%0d status=%0d occ=%0d",
                                 $time, observed.value, observed.status, observed.occ);
                end else begin
                    oldest = results_due.pop_front();
                    if (observed !== oldest) begin
                        fails++;
                        if (fails <= REPORT_CAP)
                            $display("%0t: expected val=%0d st=%0d occ=%0d, got val=%0d st=%0d occ=%0d",
                                     $time, oldest.value, oldest.status, oldest.occ,
                                     observed.value, observed.status, observed.occ);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
    end

endmodule

/* test/tb_ring_buffer_deque_core.sv */
`timescale 1ns / 100ps
module tb_ring_buffer_deque_core;
    import rbd_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int PHASE_ITEMS  = 282;
    // ~1150 items, some with heavy sender idling; far above any correct run
    localparam int CYCLE_LIMIT  = 200000;
    // result lands the cycle after acceptance; the SETTLE spare cycles catch stray strobes
    localparam int SETTLE       = 8;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start   = 1'b0;
    logic [1:0]              i_op    = OP_PUSH_BACK;
    logic signed [VAL_W-1:0] i_push_value = '0;

    logic                    busy;
    logic                    o_valid;
    logic signed [VAL_W-1:0] o_pop_value;
    logic [1:0]              o_status;
    logic [OCC_W-1:0]        o_occupancy;

    int fail_count;
    int pending;
    int cycle_count = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    ring_buffer_deque_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

    // predictor and scoreboard live beside the DUT, watching both channels
    ring_buffer_deque_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_op         (i_op),
        .i_push_value (i_push_value),
        .i_valid      (o_valid),
        .i_pop_value  (o_pop_value),
        .i_status     (o_status),
        .i_occupancy  (o_occupancy),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Drive one item and hold it until taken (start high, busy low at an edge).
    // start is left high so a back-to-back item needs no second assignment.
    task automatic issue(input t_op op, input logic [VAL_W-1:0] value);
        start        <= 1'b1;
        i_op         <= op;
        i_push_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Sender idles a cycle with odds idle_pct out of 100, repeatedly.
    task automatic sender_idle(input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Hold off until every predicted result has come back.
    task automatic wait_results;
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Extremes show up often; otherwise a full random word.
    function automatic logic [VAL_W-1:0] pick_word;
        case ($urandom_range(7))
            0:       return {1'b1, {(VAL_W-1){1'b0}}};
            1:       return {1'b0, {(VAL_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Random ops in runs with a push bias: push-heavy runs drive the deque
    // into full (dropped pushes), pop-heavy runs drain it into empty pops,
    // balanced runs wander around the middle and wrap both pointers.
    task automatic run_phase(input int n_items, input int idle_pct);
        int left;
        int run_len;
        int push_pct;
        left = n_items;
        while (left > 0) begin
            run_len = $urandom_range(8, 40);
            case ($urandom_range(2))
                0:       push_pct = 85;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            for (int k = 0; k < run_len && left > 0; k++) begin
                sender_idle(idle_pct);
                if ($urandom_range(99) < push_pct)
                    issue($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
                else
                    issue($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, pick_word());
                left--;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pops on empty from either end
        issue(OP_POP_BACK,  32'hFFFF_FFFF);
        issue(OP_POP_FRONT, 32'h0000_0000);
        // front push wraps head below zero; then empty from both ends
        issue(OP_PUSH_FRONT, 32'h8000_0000);
        issue(OP_PUSH_BACK,  32'h7FFF_FFFF);
        issue(OP_POP_BACK,   '0);
        issue(OP_POP_FRONT,  '0);
        // fill to capacity from both ends, mixing extreme and random words
        for (int k = 0; k < DEPTH; k++) begin
            case (k % 4)
                0:       issue(OP_PUSH_BACK,  '1);
                1:       issue(OP_PUSH_FRONT, 32'h8000_0000);
                2:       issue(OP_PUSH_BACK,  32'h7FFF_FFFF);
                default: issue(OP_PUSH_FRONT, VAL_W'($urandom));
            endcase
        end
        // full: both pushes are dropped
        issue(OP_PUSH_BACK,  32'h5555_5555);
        issue(OP_PUSH_FRONT, 32'hAAAA_AAAA);

        // sender paused until every result is back, then the random phases;
        // the result side cannot stall, so only sender idling varies
        wait_results();
        run_phase(PHASE_ITEMS, 0);
        wait_results();
        run_phase(PHASE_ITEMS, 82);
        run_phase(PHASE_ITEMS, 0);
        wait_results();
        run_phase(PHASE_ITEMS, 18);

        wait_results();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
